// ===== src/tpq_pkg.sv =====
// ============================================================================
// tpq_pkg: shared types and codes for the threshold priority queue
// Request codes, status codes, threshold width and reset value, and the
// per-request control struct that the core hands to every cell.
// ============================================================================
`default_nettype none

package tpq_pkg;

	localparam int THR_W = 32;
	localparam logic signed [THR_W-1:0] THR_RESET = 32'sd59;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_PRIO   = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// One-hot (or all-zero) action applied by every cell in the same cycle.
	typedef struct packed {
		logic ins_tail;
		logic ins_prio;
		logic shift_left;
	} tpq_ctrl_t;

endpackage

`default_nettype wire

// ===== src/tpq_cell.sv =====
// ============================================================================
// tpq_cell: one entry of the queue's shift chain
// Holds one value, flags whether it belongs to the leading priority run, and
// loads the new value, its left neighbor or its right neighbor per request.
// ============================================================================
`default_nettype none

module tpq_cell
	import tpq_pkg::*;
#(
	parameter int INDEX      = 0,
	parameter int VALUE_BITS = 32,
	parameter int CNT_W      = 5
) (
	input  wire                         clk,
	input  wire tpq_ctrl_t              ctrl,
	input  wire [CNT_W-1:0]             count,
	input  wire signed [VALUE_BITS-1:0] new_val,
	input  wire signed [THR_W-1:0]      thr,
	input  wire signed [VALUE_BITS-1:0] left_val,
	input  wire signed [VALUE_BITS-1:0] right_val,
	input  wire                         run_in,
	output logic                        run_out,
	output logic signed [VALUE_BITS-1:0] val_out
);

	localparam int CMP_W = (VALUE_BITS > THR_W) ? VALUE_BITS : THR_W;

	logic signed [VALUE_BITS-1:0] val_q;
	logic signed [CMP_W-1:0]      val_ext;
	logic signed [CMP_W-1:0]      thr_ext;
	logic                         occupied;
	logic                         at_tail;
	logic                         my_run;

	assign val_ext  = CMP_W'(val_q);
	assign thr_ext  = CMP_W'(thr);
	assign occupied = count > CNT_W'(INDEX);
	assign at_tail  = count == CNT_W'(INDEX);
	assign my_run   = occupied && (val_ext > thr_ext);
	assign run_out  = run_in && my_run;
	assign val_out  = val_q;

	// On a priority insert, the insertion point is the first cell that the leading
	// run does not reach; every cell past it moves one place toward the tail.
	always_ff @(posedge clk) begin
		if (ctrl.shift_left) begin
			val_q <= right_val;
		end else if (ctrl.ins_tail) begin
			if (at_tail) begin
				val_q <= new_val;
			end
		end else if (ctrl.ins_prio) begin
			if (run_in && !my_run) begin
				val_q <= new_val;
			end else if (!run_in) begin
				val_q <= left_val;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/threshold_priority_queue_core.sv =====
// ============================================================================
// threshold_priority_queue_core: bounded two-class ordered queue
// A chain of cells holds the entries head first; appends, priority inserts of
// above-threshold values behind the leading above-threshold run, and head
// removes are all applied to every cell of the chain together.
// ============================================================================
// The result strobe (done) rises in the cycle after a request is taken.
// Throughput: one request per cycle; busy stays low, since the insertion
// point comes from a run flag rippled through the cells in the same cycle.
// Results cannot be stalled and are shown for exactly one cycle.
// Reset clears the entry count and loads the threshold with 59; cell
// contents are not cleared, as no cell is read above the count.
`default_nettype none

module threshold_priority_queue_core
	import tpq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire [1:0]                    req_type,
	input  wire signed [VALUE_BITS-1:0]  value,
	output logic                         done,
	output logic signed [VALUE_BITS-1:0] removed_value,
	output logic                         removed_valid,
	output logic [1:0]                   status,
	output logic [CNT_W-1:0]             occupancy,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire signed [THR_W-1:0]       cfg_data
);

	localparam int CMP_W = (VALUE_BITS > THR_W) ? VALUE_BITS : THR_W;

	logic [CNT_W-1:0]             count_q;
	logic signed [THR_W-1:0]      thr_q;
	logic                         done_q;
	logic signed [VALUE_BITS-1:0] removed_value_q;
	logic                         removed_valid_q;
	logic [1:0]                   status_q;
	logic [CNT_W-1:0]             occupancy_q;

	logic                         accept;
	logic                         full;
	logic                         empty;
	logic                         is_insert;
	logic                         new_prio;
	tpq_ctrl_t                    ctrl;
	logic [CNT_W-1:0]             count_next;
	logic [1:0]                   status_next;

	logic signed [VALUE_BITS-1:0] cell_val [DEPTH];
	logic                         run [DEPTH+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign is_insert = req_type inside {REQ_APPEND, REQ_PRIO};
	assign new_prio  = CMP_W'(value) > CMP_W'(thr_q);

	always_comb begin
		ctrl        = '0;
		count_next  = count_q;
		status_next = ST_OK;
		if (accept) begin
			case (req_type)
				REQ_APPEND, REQ_PRIO: begin
					if (full) begin
						status_next = ST_FULL;
					end else begin
						count_next = count_q + CNT_W'(1);
						if (req_type == REQ_PRIO && new_prio) begin
							ctrl.ins_prio = 1'b1;
						end else begin
							ctrl.ins_tail = 1'b1;
						end
					end
				end
				REQ_REMOVE: begin
					if (empty) begin
						status_next = ST_EMPTY;
					end else begin
						count_next      = count_q - CNT_W'(1);
						ctrl.shift_left = 1'b1;
					end
				end
				default: begin
					status_next = ST_OK;
				end
			endcase
		end
	end

	assign run[0] = 1'b1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VALUE_BITS-1:0] left_v;
		logic signed [VALUE_BITS-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = value;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end

		tpq_cell #(
			.INDEX      (i),
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.new_val   (value),
			.thr       (thr_q),
			.left_val  (left_v),
			.right_val (right_v),
			.run_in    (run[i]),
			.run_out   (run[i+1]),
			.val_out   (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			thr_q   <= THR_RESET;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_value_q <= ctrl.shift_left ? cell_val[0] : '0;
			removed_valid_q <= ctrl.shift_left;
			status_q        <= status_next;
			occupancy_q     <= count_next;
		end
	end

	assign done          = done_q;
	assign removed_value = removed_value_q;
	assign removed_valid = removed_valid_q;
	assign status        = status_q;
	assign occupancy     = occupancy_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_remove_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_REMOVE && !empty) |=>
		(done && removed_valid && status == ST_OK && count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove on a non-empty queue did not pop the head");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_insert && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted insert did not add an entry");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (!removed_valid && removed_value == '0))
		else $error("error result carries a removed value");

	a_occ_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (occupancy == count_q))
		else $error("reported occupancy differs from entry count");

endmodule

`default_nettype wire

// ===== dv/tpq_order_checker.sv =====
// ----------------------------------------------------------------------------
// tpq_order_checker: expected-result tracker for the threshold priority queue
// Watches the request, result and threshold channels of the core, keeps its
// own copy of the queue contents and threshold, and compares every result
// strobe field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module tpq_order_checker
	import tpq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire                         busy,
	input  wire [1:0]                   req_type,
	input  wire signed [VALUE_BITS-1:0] value,
	input  wire                         done,
	input  wire signed [VALUE_BITS-1:0] removed_value,
	input  wire                         removed_valid,
	input  wire [1:0]                   status,
	input  wire [CNT_W-1:0]             occupancy,
	input  wire                         cfg_valid,
	input  wire                         cfg_ready,
	input  wire signed [THR_W-1:0]      cfg_data,
	output int                          fail_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] removed_value;
		logic                         removed_valid;
		logic [1:0]                   status;
		logic [CNT_W-1:0]             occupancy;
	} queue_result_t;

	logic signed [VALUE_BITS-1:0] cells [DEPTH];
	int                           entry_total;
	logic signed [THR_W-1:0]      threshold;
	queue_result_t                awaited_results [$];
	int                           misses;

	// Applies one request to the shadow queue and returns what the core should report.
	function automatic queue_result_t apply_request(input logic [1:0] rt,
			input logic signed [VALUE_BITS-1:0] v);
		queue_result_t r;
		int pos;
		int k;
		r = '0;
		case (rt)
			REQ_APPEND, REQ_PRIO: begin
				if (entry_total >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = entry_total;
					// A priority value lands right behind the leading above-threshold run.
					if (rt == REQ_PRIO && v > threshold) begin
						pos = 0;
						while (pos < entry_total && cells[pos] > threshold)
							pos++;
					end
					for (k = entry_total; k > pos; k--)
						cells[k] = cells[k-1];
					cells[pos] = v;
					entry_total++;
				end
			end
			REQ_REMOVE: begin
				if (entry_total == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed_value = cells[0];
					r.removed_valid = 1'b1;
					for (k = 0; k < entry_total - 1; k++)
						cells[k] = cells[k+1];
					entry_total--;
				end
			end
			default: ;
		endcase
		r.occupancy = CNT_W'(entry_total);
		return r;
	endfunction

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			misses++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			entry_total = 0;
			threshold = THR_RESET;
			awaited_results.delete();
			misses = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// New request first, so a same-edge result still pops the older one.
			// A request taken at the same edge as a threshold write sees the old threshold.
			if (start && !busy)
				awaited_results.push_back(apply_request(req_type, value));
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
			if (done) begin
				if (awaited_results.size() == 0) begin
					misses++;
					$display("%0t: result expected none, actual value %0d status %0d",
						$time, removed_value, status);
				end else begin
					want = awaited_results.pop_front();
					compare_field("removed_value", longint'(want.removed_value),
						longint'(removed_value));
					compare_field("removed_valid", want.removed_valid, removed_valid);
					compare_field("status", want.status, status);
					compare_field("occupancy", want.occupancy, occupancy);
				end
			end
			fail_count <= misses;
			pending <= awaited_results.size();
		end
	end

endmodule

// ===== dv/threshold_priority_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// threshold_priority_queue_core_tb: request stimulus and verdict
// Drives a directed sequence through the empty, full and unused-code cases,
// then random request mixes over several threshold settings and sender
// idling rates; a separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module threshold_priority_queue_core_tb
	import tpq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = 16;
	localparam int VALUE_BITS  = 32;
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 238;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [1:0]                   req_type = REQ_APPEND;
	logic signed [VALUE_BITS-1:0] value = '0;
	logic                         cfg_valid = 1'b0;
	logic signed [THR_W-1:0]      cfg_data = '0;
	logic                         busy;
	logic                         done;
	logic signed [VALUE_BITS-1:0] removed_value;
	logic                         removed_valid;
	logic [1:0]                   status;
	logic [CNT_W-1:0]             occupancy;
	logic                         cfg_ready;
	int                           fail_count;
	int                           pending;
	logic signed [THR_W-1:0]      cur_thr = THR_RESET;
	int                           phase_idle [PHASES] = '{0, 55, 0, 12, 55, 0};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	threshold_priority_queue_core #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.done(done),
		.removed_value(removed_value),
		.removed_valid(removed_valid),
		.status(status),
		.occupancy(occupancy),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	tpq_order_checker #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.done(done),
		.removed_value(removed_value),
		.removed_valid(removed_valid),
		.status(status),
		.occupancy(occupancy),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	task automatic issue(input logic [1:0] rt, input logic signed [VALUE_BITS-1:0] v);
		start <= 1'b1;
		req_type <= rt;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stops issuing until every outstanding request has produced its result.
	task automatic settle_queue();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic load_threshold(input logic signed [THR_W-1:0] t);
		settle_queue();
		cfg_valid <= 1'b1;
		cfg_data <= t;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_thr = t;
	endtask

	// Mixes full-range values with ones right around the current threshold.
	function automatic logic signed [VALUE_BITS-1:0] pick_value();
		longint near;
		longint off;
		case ($urandom_range(9))
			4, 5, 6: begin
				off = $urandom_range(6);
				near = longint'(cur_thr) + off - 3;
				if (near < longint'(VAL_MIN))
					near = longint'(VAL_MIN);
				if (near > longint'(VAL_MAX))
					near = longint'(VAL_MAX);
				return VALUE_BITS'(near);
			end
			7: return VAL_MIN;
			8: return VAL_MAX;
			9: return VALUE_BITS'($urandom_range(200)) - VALUE_BITS'(100);
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int phase;
		int sent;
		int ins_pct;
		logic [1:0] rt;
		int k;
		int waited;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, unused code, priority ordering at the threshold edge.
		issue(REQ_REMOVE, 32'sd5);
		issue(REQ_UNUSED, 32'sh1234_5678);
		issue(REQ_PRIO, 32'sd100);
		issue(REQ_APPEND, VAL_MAX);
		issue(REQ_APPEND, VAL_MIN);
		issue(REQ_PRIO, 32'sd60);
		issue(REQ_PRIO, 32'sd59);
		issue(REQ_PRIO, -32'sd1);
		issue(REQ_APPEND, 32'sd0);
		issue(REQ_REMOVE, 32'sd0);
		for (k = 0; k < 10; k++)
			issue(k[0] ? REQ_PRIO : REQ_APPEND, pick_value());
		// The queue is full now.
		issue(REQ_APPEND, 32'sd7);
		issue(REQ_PRIO, 32'sd1000);
		issue(REQ_UNUSED, VAL_MAX);
		issue(REQ_REMOVE, VAL_MIN);
		issue(REQ_PRIO, 32'sd61);

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1: load_threshold(VAL_MIN);
				2: load_threshold(VAL_MAX);
				3: load_threshold(32'sd0);
				4: load_threshold(THR_W'($urandom));
				5: load_threshold(-32'sd1);
				default: ;
			endcase
			sent = 0;
			ins_pct = 50;
			while (sent < PHASE_ITEMS) begin
				// Swing the fill level between empty and full in bursts.
				if (sent % 40 == 0)
					case ($urandom_range(2))
						0: ins_pct = 85;
						1: ins_pct = 50;
						default: ins_pct = 20;
					endcase
				if (sent == PHASE_ITEMS / 2)
					settle_queue();
				idle_gap(phase_idle[phase]);
				if ($urandom_range(99) < 3)
					rt = REQ_UNUSED;
				else if ($urandom_range(99) < ins_pct)
					rt = ($urandom_range(99) < 60) ? REQ_PRIO : REQ_APPEND;
				else
					rt = REQ_REMOVE;
				issue(rt, pick_value());
				if (rt != REQ_UNUSED)
					sent++;
			end
		end

		start <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending != 0 && waited < 1000);
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
